// File: design/slcm_pkg.sv
// ---------------------------------------------------------------------------
// slcm_pkg: shared constants of the set-associative LRU cache model
// Outcome codes, opcode decode, register indexes and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none
package slcm_pkg;
    // parameter defaults
    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 64;

    // register file
    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 5;
    localparam logic [1:0]  CFG_SET_BITS   = 2'd0;
    localparam logic [1:0]  CFG_WAYS       = 2'd1;
    localparam logic [1:0]  CFG_BLOCK_BITS = 2'd2;
    localparam int          BLOCK_BITS_MAX = 16;

    // opcode: high bit selects a modify
    localparam int KIND_W       = 2;
    localparam int KIND_MOD_BIT = 1;

    // lookup outcomes
    localparam int         RES_W     = 2;
    localparam logic [1:0] RES_HIT   = 2'd0;
    localparam logic [1:0] RES_MISS  = 2'd1;
    localparam logic [1:0] RES_EVICT = 2'd2;
    localparam logic [1:0] RES_NONE  = 2'd3;

    localparam int CNT_W = 32;
endpackage
`default_nettype wire

// File: design/slcm_if.sv
// ---------------------------------------------------------------------------
// slcm_if: access and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none
interface slcm_in_if #(parameter int ADDR_WIDTH = slcm_pkg::ADDR_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic [slcm_pkg::KIND_W-1:0]   access_kind;
    logic [ADDR_WIDTH-1:0]         address;
    modport source (output valid, output access_kind, output address, input ready);
    modport sink   (input valid, input access_kind, input address, output ready);
endinterface

interface slcm_out_if;
    logic                          valid;
    logic                          ready;
    logic [slcm_pkg::RES_W-1:0]    first_outcome;
    logic [slcm_pkg::RES_W-1:0]    second_outcome;
    logic [slcm_pkg::CNT_W-1:0]    hit_count;
    logic [slcm_pkg::CNT_W-1:0]    miss_count;
    logic [slcm_pkg::CNT_W-1:0]    eviction_count;
    modport source (output valid, output first_outcome, output second_outcome,
                    output hit_count, output miss_count, output eviction_count,
                    input ready);
    modport sink   (input valid, input first_outcome, input second_outcome,
                    input hit_count, input miss_count, input eviction_count,
                    output ready);
endinterface
`default_nettype wire

// File: design/slcm_ram.sv
// ---------------------------------------------------------------------------
// slcm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module slcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/slcm_front.sv
// ---------------------------------------------------------------------------
// slcm_front: configuration registers and address split
// Holds the registers, clamps them and splits each access into set and tag.
// ---------------------------------------------------------------------------
`default_nettype none
module slcm_front #(
    parameter int MAX_SETS   = slcm_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = slcm_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = slcm_pkg::ADDR_WIDTH_DEF,
    localparam int SETW  = $clog2(MAX_SETS + 1) - 1,
    localparam int FILLW = $clog2(MAX_WAYS + 1),
    localparam int TAGW  = ADDR_WIDTH - 2,
    localparam int JOBW  = 1 + FILLW + SETW + TAGW
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [slcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [slcm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    slcm_in_if.sink                            i_req,
    input  wire                                i_q_full,
    output logic                               o_push,
    output logic [JOBW-1:0]                    o_job
);
    logic [3:0] r_set_bits;
    logic [3:0] r_ways;
    logic [4:0] r_block_bits;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 4'd1;
            r_ways       <= 4'd1;
            r_block_bits <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slcm_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[3:0];
                slcm_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                slcm_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [4:0]            sb;
    logic [4:0]            bb;
    logic [FILLW-1:0]      ways;
    logic [5:0]            split;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [ADDR_WIDTH-1:0] tag_full;
    logic [SETW-1:0]       set_keep;
    logic [SETW-1:0]       set_idx;

    // clamp registers into range, split the address
    always_comb begin
        if (r_set_bits == 4'd0)           sb = 5'd1;
        else if (int'(r_set_bits) > SETW) sb = 5'(SETW);
        else                              sb = {1'b0, r_set_bits};
        if (r_block_bits == 5'd0)                              bb = 5'd1;
        else if (int'(r_block_bits) > slcm_pkg::BLOCK_BITS_MAX) bb = 5'(slcm_pkg::BLOCK_BITS_MAX);
        else                                                   bb = r_block_bits;
        if (r_ways == 4'd0)               ways = FILLW'(1);
        else if (int'(r_ways) > MAX_WAYS) ways = FILLW'(MAX_WAYS);
        else                              ways = FILLW'(r_ways);
        split    = {1'b0, sb} + {1'b0, bb};
        shifted  = i_req.address >> bb;
        set_keep = ~({SETW{1'b1}} << sb);
        set_idx  = shifted[SETW-1:0] & set_keep;
        tag_full = i_req.address >> split;
    end

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;
    assign o_job       = {i_req.access_kind[slcm_pkg::KIND_MOD_BIT], ways, set_idx,
                          tag_full[TAGW-1:0]};
endmodule
`default_nettype wire

// File: design/slcm_queue.sv
// ---------------------------------------------------------------------------
// slcm_queue: short job queue between front and back
// Two-entry FIFO; full and empty from a separate occupancy count.
// ---------------------------------------------------------------------------
`default_nettype none
module slcm_queue #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
endmodule
`default_nettype wire

// File: design/slcm_back.sv
// ---------------------------------------------------------------------------
// slcm_back: set lookup and LRU update
// Reads a set row, resolves hit, fill or eviction, writes the row back
// and holds the result beat with the running counters.
// ---------------------------------------------------------------------------
`default_nettype none
module slcm_back #(
    parameter int MAX_SETS   = slcm_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = slcm_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = slcm_pkg::ADDR_WIDTH_DEF,
    localparam int SETW  = $clog2(MAX_SETS + 1) - 1,
    localparam int FILLW = $clog2(MAX_WAYS + 1),
    localparam int TAGW  = ADDR_WIDTH - 2,
    localparam int JOBW  = 1 + FILLW + SETW + TAGW
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_valid,
    input  wire  [JOBW-1:0] i_job,
    output logic            o_pop,
    slcm_out_if.source      o_rsp
);
    localparam int AGEW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NSETS = 2 ** SETW;
    localparam int ROWW  = MAX_WAYS * (TAGW + 1 + AGEW) + FILLW;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state                  r_state;
    logic [NSETS-1:0]        r_row_ok;
    logic                    r_ok;
    logic                    r_mod;
    logic [FILLW-1:0]        r_ways;
    logic [SETW-1:0]         r_set;
    logic [TAGW-1:0]         r_tag;
    logic                    r_out_valid;
    logic [1:0]              r_first;
    logic [1:0]              r_second;
    logic [slcm_pkg::CNT_W-1:0] r_hits;
    logic [slcm_pkg::CNT_W-1:0] r_misses;
    logic [slcm_pkg::CNT_W-1:0] r_evicts;

    logic [ROWW-1:0] rd_row;
    logic [ROWW-1:0] wr_row;
    logic            issue;
    logic            q_mod;
    logic [FILLW-1:0] q_ways;
    logic [SETW-1:0] q_set;
    logic [TAGW-1:0] q_tag;

    assign {q_mod, q_ways, q_set, q_tag} = i_job;
    assign issue = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop = issue;

    slcm_ram #(.WIDTH(ROWW), .DEPTH(NSETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOOK),
        .i_waddr (r_set),
        .i_wdata (wr_row),
        .i_re    (issue),
        .i_raddr (q_set),
        .o_rdata (rd_row)
    );

    logic [TAGW-1:0]  tags   [MAX_WAYS];
    logic [AGEW-1:0]  ages   [MAX_WAYS];
    logic [MAX_WAYS-1:0] valid;
    logic [FILLW-1:0] fill;
    logic [TAGW-1:0]  n_tags [MAX_WAYS];
    logic [AGEW-1:0]  n_ages [MAX_WAYS];
    logic [MAX_WAYS-1:0] n_valid;
    logic [FILLW-1:0] n_fill;
    logic             hit;
    logic             found_free;
    logic             found_old;
    logic             do_fill;
    logic [AGEW-1:0]  hit_way;
    logic [AGEW-1:0]  free_way;
    logic [AGEW-1:0]  victim;
    logic [AGEW-1:0]  oldest;
    logic [AGEW-1:0]  way;
    logic [AGEW:0]    old_age;
    logic [1:0]       n_first;

    // unpack row; a row never written reads as empty
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i] = rd_row[i*TAGW +: TAGW];
            ages[i] = r_ok ? rd_row[MAX_WAYS*(TAGW+1) + i*AGEW +: AGEW] : '0;
            valid[i] = r_ok ? rd_row[MAX_WAYS*TAGW + i] : 1'b0;
        end
        fill = r_ok ? rd_row[ROWW-1 -: FILLW] : '0;
    end

    // hit search, free way, LRU victim and age update
    always_comb begin
        hit = 1'b0; hit_way = '0;
        found_free = 1'b0; free_way = '0;
        found_old = 1'b0; victim = '0; oldest = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!hit && valid[i] && tags[i] == r_tag) begin
                hit = 1'b1; hit_way = AGEW'(i);
            end
            if (!found_free && !valid[i]) begin
                found_free = 1'b1; free_way = AGEW'(i);
            end
            if (valid[i] && (!found_old || ages[i] > oldest)) begin
                found_old = 1'b1; victim = AGEW'(i); oldest = ages[i];
            end
        end
        do_fill = (fill < r_ways) && found_free;
        if (hit) begin
            way = hit_way; old_age = {1'b0, ages[hit_way]}; n_first = slcm_pkg::RES_HIT;
        end else if (do_fill) begin
            way = free_way; old_age = (AGEW+1)'(MAX_WAYS); n_first = slcm_pkg::RES_MISS;
        end else begin
            way = victim; old_age = {1'b0, oldest}; n_first = slcm_pkg::RES_EVICT;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            n_tags[i]  = tags[i];
            n_valid[i] = valid[i];
            if (valid[i] && AGEW'(i) != way && {1'b0, ages[i]} < old_age)
                n_ages[i] = ages[i] + AGEW'(1);
            else
                n_ages[i] = ages[i];
        end
        n_ages[way]  = '0;
        n_valid[way] = 1'b1;
        if (!hit) n_tags[way] = r_tag;
        n_fill = (!hit && do_fill) ? fill + FILLW'(1) : fill;
        for (int i = 0; i < MAX_WAYS; i++) begin
            wr_row[i*TAGW +: TAGW]                      = n_tags[i];
            wr_row[MAX_WAYS*TAGW + i]                   = n_valid[i];
            wr_row[MAX_WAYS*(TAGW+1) + i*AGEW +: AGEW]  = n_ages[i];
        end
        wr_row[ROWW-1 -: FILLW] = n_fill;
    end

    // sequencer, row-written flags, result beat and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_ok    <= '0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_rsp.ready) r_out_valid <= 1'b0;
                    if (issue) begin
                        r_ok    <= r_row_ok[q_set];
                        r_mod   <= q_mod;
                        r_ways  <= q_ways;
                        r_set   <= q_set;
                        r_tag   <= q_tag;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // result register is empty here: issue needed it free
                    r_row_ok[r_set] <= 1'b1;
                    r_out_valid     <= 1'b1;
                    r_first         <= n_first;
                    r_second        <= r_mod ? slcm_pkg::RES_HIT : slcm_pkg::RES_NONE;
                    r_hits   <= r_hits + slcm_pkg::CNT_W'(hit) + slcm_pkg::CNT_W'(r_mod);
                    r_misses <= r_misses + slcm_pkg::CNT_W'(!hit);
                    r_evicts <= r_evicts + slcm_pkg::CNT_W'(!hit && !do_fill);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.first_outcome  = r_first;
    assign o_rsp.second_outcome = r_second;
    assign o_rsp.hit_count      = r_hits;
    assign o_rsp.miss_count     = r_misses;
    assign o_rsp.eviction_count = r_evicts;
endmodule
`default_nettype wire

// File: design/set_assoc_lru_cache_model_unit.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_model_unit: set-associative cache model, true LRU
// Front splits accesses, a two-entry queue decouples, back updates sets.
// ---------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_req     in   access_kind, address
//  o_rsp     out  first/second outcome, hit/miss/eviction counts
//  i_cfg_*   in   register index and write data, no handshake
//
//  In the back end each access reads the set row from the RAM, then
//  resolves it and writes it back; a modify needs no extra
//  pass since its second lookup hits the line just made most recent.
//  Reset is synchronous; rows carry flip-flop written flags, no clear pass.
//  The front stalls only when the queue is full; the back waits on o_rsp.
// ---------------------------------------------------------------------------
`default_nettype none
module set_assoc_lru_cache_model_unit #(
    parameter int MAX_SETS   = slcm_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = slcm_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = slcm_pkg::ADDR_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [slcm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [slcm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    slcm_in_if.sink                           i_req,
    slcm_out_if.source                        o_rsp
);
    localparam int SETW  = $clog2(MAX_SETS + 1) - 1;
    localparam int FILLW = $clog2(MAX_WAYS + 1);
    localparam int JOBW  = 1 + FILLW + SETW + ADDR_WIDTH - 2;

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;
    logic [JOBW-1:0] job_in;
    logic [JOBW-1:0] job_out;

    slcm_front #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    slcm_queue #(.WIDTH(JOBW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    slcm_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );
endmodule
`default_nettype wire

// File: bench/tb_set_assoc_lru_cache_model_unit.sv
// ---------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model_unit: self-checking bench for the LRU cache
// Drives load, store and modify beats, predicts outcomes and counters with an
// internal LRU cache model, and checks every response beat in order across
// several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
`default_nettype none

// Predicted LRU cache state and the queue of outstanding response beats
class cache_scoreboard;
    typedef struct {
        logic [1:0]  first;
        logic [1:0]  second;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } t_rsp;

    localparam int NSETS = slcm_pkg::MAX_SETS_DEF;
    localparam int NWAYS = slcm_pkg::MAX_WAYS_DEF;

    logic [63:0] tags [NSETS][NWAYS];
    bit          vld  [NSETS][NWAYS];
    int          age  [NSETS][NWAYS];
    int          fill [NSETS];
    logic [31:0] hits, misses, evicts;
    logic [4:0]  set_bits_r, ways_r, block_bits_r;
    t_rsp        pending_rsp [$];
    int          errors;

    function new();
        for (int s = 0; s < NSETS; s++) begin
            fill[s] = 0;
            for (int w = 0; w < NWAYS; w++) begin
                vld[s][w] = 0;
                age[s][w] = 0;
                tags[s][w] = '0;
            end
        end
        hits = 0; misses = 0; evicts = 0;
        set_bits_r = 1; ways_r = 1; block_bits_r = 1;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] data);
        case (idx)
            slcm_pkg::CFG_SET_BITS:   set_bits_r   = data & 5'hF;
            slcm_pkg::CFG_WAYS:       ways_r       = data & 5'hF;
            slcm_pkg::CFG_BLOCK_BITS: block_bits_r = data;
            default: ;
        endcase
    endfunction

    // Effective (clamped) field widths
    function int eff_sb();
        int msb;
        msb = $clog2(NSETS);
        return (set_bits_r == 0) ? 1 : (set_bits_r > msb) ? msb : set_bits_r;
    endfunction
    function int eff_bb();
        return (block_bits_r == 0) ? 1 :
               (block_bits_r > slcm_pkg::BLOCK_BITS_MAX) ? slcm_pkg::BLOCK_BITS_MAX
                                                         : block_bits_r;
    endfunction
    function int eff_ways();
        return (ways_r == 0) ? 1 : (ways_r > NWAYS) ? NWAYS : ways_r;
    endfunction

    // Promote a way to most recent; younger valid ways age by one
    function void promote(int s, int w, int old_age);
        for (int i = 0; i < NWAYS; i++)
            if (vld[s][i] && i != w && age[s][i] < old_age) age[s][i]++;
        age[s][w] = 0;
    endfunction

    function logic [1:0] lookup(int s, logic [63:0] tag);
        int victim, oldest;
        bit found;
        victim = 0; oldest = 0; found = 0;
        for (int i = 0; i < NWAYS; i++)
            if (vld[s][i] && tags[s][i] == tag) begin
                hits++;
                promote(s, i, age[s][i]);
                return slcm_pkg::RES_HIT;
            end
        misses++;
        if (fill[s] < eff_ways())
            for (int i = 0; i < NWAYS; i++)
                if (!vld[s][i]) begin
                    vld[s][i] = 1;
                    tags[s][i] = tag;
                    fill[s]++;
                    promote(s, i, NWAYS);
                    return slcm_pkg::RES_MISS;
                end
        // set full: evict the least recent valid way
        for (int i = 0; i < NWAYS; i++)
            if (vld[s][i] && (!found || age[s][i] > oldest)) begin
                victim = i; oldest = age[s][i]; found = 1;
            end
        evicts++;
        tags[s][victim] = tag;
        promote(s, victim, oldest);
        return slcm_pkg::RES_EVICT;
    endfunction

    // Accepted access beat: work out its response
    function void note_access(logic [1:0] kind, logic [63:0] addr);
        t_rsp r;
        int sb, bb, s;
        logic [63:0] tag;
        sb = eff_sb();
        bb = eff_bb();
        s = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
        tag = addr >> (sb + bb);
        r.first = lookup(s, tag);
        r.second = kind[slcm_pkg::KIND_MOD_BIT] ? lookup(s, tag) : slcm_pkg::RES_NONE;
        r.hits = hits; r.misses = misses; r.evicts = evicts;
        pending_rsp.push_back(r);
    endfunction

    function void check_rsp(logic [1:0] f, logic [1:0] sc, logic [31:0] h,
                            logic [31:0] m, logic [31:0] e);
        t_rsp r;
        if (pending_rsp.size() == 0) begin
            $error("response beat with no access outstanding");
            errors++;
            return;
        end
        r = pending_rsp.pop_front();
        if (f !== r.first) begin
            $error("first_outcome: expected %0d, got %0d", r.first, f); errors++;
        end
        if (sc !== r.second) begin
            $error("second_outcome: expected %0d, got %0d", r.second, sc); errors++;
        end
        if (h !== r.hits) begin
            $error("hit_count: expected %0d, got %0d", r.hits, h); errors++;
        end
        if (m !== r.misses) begin
            $error("miss_count: expected %0d, got %0d", r.misses, m); errors++;
        end
        if (e !== r.evicts) begin
            $error("eviction_count: expected %0d, got %0d", r.evicts, e); errors++;
        end
    endfunction
endclass

module tb_set_assoc_lru_cache_model_unit;
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0, KIND_STORE = 2'd1, KIND_MODIFY = 2'd2, KIND_MODIFY_HI = 2'd3
    } t_kind;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [slcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [slcm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    slcm_in_if  req_if ();
    slcm_out_if rsp_if ();

    set_assoc_lru_cache_model_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    cache_scoreboard sb_cache = new();
    t_idle           idle_mode = IDLE_NONE;
    int              hold_cycles = 0;
    logic [63:0]     line_pool [16];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit stall_now(bit sink_side);
        int pct;
        pct = (idle_mode == IDLE_BOTH) ? 13 :
              (sink_side && idle_mode == IDLE_SNK) ? 74 :
              (!sink_side && idle_mode == IDLE_SRC) ? 74 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Response side: check accepted beats, then pick next ready
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                sb_cache.check_rsp(rsp_if.first_outcome, rsp_if.second_outcome,
                                   rsp_if.hit_count, rsp_if.miss_count,
                                   rsp_if.eviction_count);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !stall_now(1);
            end
        end
    end

    // One register write; the caller drops the write enable afterwards
    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb_cache.write_reg(idx, data);
    endtask

    // One access beat, followed by an optional random gap
    task automatic send_access(logic [1:0] kind, logic [63:0] addr);
        req_if.valid       <= 1'b1;
        req_if.access_kind <= kind;
        req_if.address     <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        sb_cache.note_access(kind, addr);
        if (stall_now(0)) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while (stall_now(0));
        end
    endtask

    // Wait for all outstanding responses, then let the pipeline settle
    task automatic drain();
        int guard;
        guard = 0;
        req_if.valid <= 1'b0;
        while (sb_cache.pending_rsp.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic configure(logic [4:0] sbits, logic [4:0] ways, logic [4:0] bbits);
        write_reg(slcm_pkg::CFG_SET_BITS, sbits);
        write_reg(slcm_pkg::CFG_WAYS, ways);
        write_reg(slcm_pkg::CFG_BLOCK_BITS, bbits);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pool of lines crowded into a few sets so that hits and evictions occur
    task automatic refill_pool();
        int s, b;
        logic [63:0] tag;
        s = sb_cache.eff_sb();
        b = sb_cache.eff_bb();
        foreach (line_pool[i]) begin
            tag = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 5));
            line_pool[i] = (tag << (s + b)) | (64'($urandom_range(0, 3)) << b);
        end
    endtask

    function automatic logic [63:0] pick_addr();
        logic [63:0] offs;
        offs = ((64'd1 << sb_cache.eff_bb()) - 64'd1) & {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
        return line_pool[$urandom_range(0, 15)] | offs;
    endfunction

    // Register settings per phase: set bits, ways, block bits
    logic [4:0] phase_cfg [8][3] = '{
        '{5'd2,  5'd4,  5'd3},  '{5'd8,  5'd8,  5'd16}, '{5'd0,  5'd0,  5'd0},
        '{5'd15, 5'd15, 5'd31}, '{5'd1,  5'd2,  5'd5},  '{5'd3,  5'd8,  5'd2},
        '{5'd9,  5'd9,  5'd17}, '{5'd4,  5'd1,  5'd1}
    };

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.access_kind <= KIND_LOAD;
        req_if.address     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, hits, fills, eviction, opcode three
        send_access(KIND_LOAD,      64'h0);
        send_access(KIND_LOAD,      64'h0);
        send_access(KIND_STORE,     64'h1);
        send_access(KIND_MODIFY,    64'h4);
        send_access(KIND_LOAD,      64'h0);
        send_access(KIND_LOAD,      '1);
        send_access(KIND_MODIFY_HI, '1);
        send_access(KIND_STORE,     64'h2);
        send_access(KIND_MODIFY_HI, 64'h8000_0000_0000_0000);
        drain();
        // lines kept across a change of split, then full-width fields
        configure(5'd8, 5'd8, 5'd16);
        send_access(KIND_LOAD,   64'h0);
        send_access(KIND_LOAD,   '1);
        send_access(KIND_MODIFY, 64'h00FF_0000);
        for (int t = 0; t < 10; t++)
            send_access(KIND_STORE, 64'(t) << 24);
        send_access(KIND_LOAD,   64'h0);
        drain();

        // Random phases
        for (int p = 0; p < 8; p++) begin
            configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            idle_mode = t_idle'(p % 4);
            refill_pool();
            if (p == 1) hold_cycles = 400;
            for (int n = 0; n < 210; n++) begin
                send_access(2'($urandom_range(0, 3)), pick_addr());
                if (p == 2 && n == 100) begin
                    req_if.valid <= 1'b0;
                    while (sb_cache.pending_rsp.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (sb_cache.pending_rsp.size() != 0) begin
            $error("%0d responses never arrived", sb_cache.pending_rsp.size());
            sb_cache.errors++;
        end
        if (sb_cache.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
